>>> hw/rtl/bcp_pkg.sv
// bcp_pkg: shared types, constants and the square lookup for the bifid cipher block
// used by bcp_locate, bcp_cell and bifid_cipher_period_five; depends on nothing else

package bcp_pkg;

	localparam int PERIOD_DEF = 5;
	localparam int SIDE       = 5;
	localparam int CELLS      = SIDE * SIDE;
	localparam int LETTER_W   = 5;
	localparam int COORD_W    = 3;
	localparam int CFG_W      = 35;
	localparam int CFG_REGS   = 4;
	localparam int SQ_W       = CFG_REGS * CFG_W;
	localparam int CFG_IDX_W  = 3;

	localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
	localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SQ_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SQ_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SQ_C = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SQ_D = 3'd4;

	localparam logic MODE_ENC = 1'b0;

	typedef struct packed {
		logic [LETTER_W-1:0] letter;
		logic                last;
	} in_item_t;

	typedef struct packed {
		logic [LETTER_W-1:0] out_letter;
		logic                end_of_run;
	} out_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} coord_t;

	typedef struct packed {
		logic load;
		logic shift;
	} chain_ctl_t;

	// cell n of the square sits at bit 5n of the concatenated registers
	function automatic logic [LETTER_W-1:0] sq_cell(input logic [SQ_W-1:0] flat,
		input coord_t at);
		logic [4:0] idx;
		logic [7:0] pos;
		idx = {at.row[2:0], 2'b00} + {2'b00, at.row} + {2'b00, at.col};
		pos = {1'b0, idx, 2'b00} + {3'b000, idx};
		return flat[pos +: LETTER_W];
	endfunction

endpackage

>>> hw/rtl/bifid_cipher_period_five.sv
// bifid_cipher_period_five: top level, coordinate buffer, block reordering and output chain
// depends on bcp_pkg, bcp_locate and bcp_cell
//
// Usage
//   in channel  (in_valid, in_ready, in_item): one letter index per item, last flushes a
//   partial block. Each letter is located in the square as it is accepted.
//   out channel (out_valid, out_ready, out_item): one letter per item, end_of_run set on
//   the last letter of each block of up to PERIOD letters.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 mode (0 encrypt,
//   1 decrypt), 1 to 4 the square words; always ready, write only while the block is idle.
// Timing
//   the item that completes a block leaves it pending; the pending block is reordered
//   into the output chain once the chain is empty or its final result is taken, and
//   results then follow one per cycle from the chain registers while out_ready holds.
//   The input keeps taking letters while the chain drains, so with no stall one letter
//   per cycle is sustained. The rate is set by the output chain: one cell shift per result.
// Reset clears mode, square, fill count and chain occupancy; the coordinate buffer is not
// cleared. When the receiver stalls the chain holds; input carries on until the next
// block is complete, then in_ready drops until the chain's final result is taken.

module bifid_cipher_period_five #(
	parameter int PERIOD = bcp_pkg::PERIOD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  bcp_pkg::in_item_t             in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output bcp_pkg::out_item_t            out_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bcp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bcp_pkg::CFG_W-1:0]     cfg_data
);

	localparam int FILL_W = $clog2(PERIOD);
	localparam int CNT_W  = $clog2(PERIOD + 1);
	localparam int IW     = $clog2(2 * PERIOD);

	logic                        mode_q;
	logic [bcp_pkg::CFG_W-1:0]   sq_q [bcp_pkg::CFG_REGS];
	logic [bcp_pkg::SQ_W-1:0]    sq_flat;
	logic [FILL_W-1:0]           fill_q;
	logic [CNT_W-1:0]            len_q;
	logic [CNT_W-1:0]            out_cnt_q;
	logic                        pending_q;
	bcp_pkg::coord_t             buf_q [PERIOD];
	bcp_pkg::coord_t             loc;
	bcp_pkg::coord_t             load_val [PERIOD];
	bcp_pkg::coord_t             chain [PERIOD];
	logic [bcp_pkg::COORD_W-1:0] seq_e [2*PERIOD];
	logic [bcp_pkg::COORD_W-1:0] seq_d [2*PERIOD];
	bcp_pkg::chain_ctl_t         ctl;
	logic                        in_acc;
	logic                        out_acc;
	logic                        closes;
	logic                        xfer;

	assign sq_flat   = {sq_q[3], sq_q[2], sq_q[1], sq_q[0]};
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bcp_pkg::MODE_ENC;
			for (int i = 0; i < bcp_pkg::CFG_REGS; i++) begin
				sq_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bcp_pkg::REG_MODE: mode_q   <= cfg_data[0];
				bcp_pkg::REG_SQ_A: sq_q[0] <= cfg_data;
				bcp_pkg::REG_SQ_B: sq_q[1] <= cfg_data;
				bcp_pkg::REG_SQ_C: sq_q[2] <= cfg_data;
				bcp_pkg::REG_SQ_D: sq_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	bcp_locate u_locate (
		.sq_flat (sq_flat),
		.letter  (in_item.letter),
		.loc     (loc)
	);

	// the chain can take the waiting block when empty or as its final result is taken
	assign out_valid = (out_cnt_q != '0);
	assign out_acc   = out_valid && out_ready;
	assign xfer      = pending_q && ((out_cnt_q == '0) || ((out_cnt_q == CNT_W'(1)) && out_ready));
	assign in_ready  = !pending_q || xfer;
	assign in_acc    = in_valid && in_ready;
	assign closes    = in_item.last || (fill_q == FILL_W'(PERIOD - 1));

	always_ff @(posedge clk) begin
		if (in_acc) begin
			buf_q[fill_q] <= loc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			len_q     <= '0;
			pending_q <= 1'b0;
			out_cnt_q <= '0;
		end else begin
			if (in_acc) begin
				if (closes) begin
					fill_q <= '0;
					len_q  <= CNT_W'(fill_q) + CNT_W'(1);
				end else begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
			if (in_acc && closes) begin
				pending_q <= 1'b1;
			end else if (xfer) begin
				pending_q <= 1'b0;
			end
			if (xfer) begin
				out_cnt_q <= len_q;
			end else if (out_acc) begin
				out_cnt_q <= out_cnt_q - CNT_W'(1);
			end
		end
	end

	// block reordering: encrypt reads rows then columns in pairs,
	// decrypt splits the interleaved sequence into halves
	always_comb begin
		for (int i = 0; i < 2 * PERIOD; i++) begin
			seq_e[i] = '0;
			seq_d[i] = (i % 2 == 0) ? buf_q[i/2].row : buf_q[i/2].col;
			for (int k = 0; k < PERIOD; k++) begin
				if ((IW'(k) == IW'(i)) && (IW'(i) < IW'(len_q))) begin
					seq_e[i] = buf_q[k].row;
				end
				if ((IW'(k) + IW'(len_q)) == IW'(i)) begin
					seq_e[i] = buf_q[k].col;
				end
			end
		end
		for (int j = 0; j < PERIOD; j++) begin
			if (mode_q == bcp_pkg::MODE_ENC) begin
				load_val[j].row = seq_e[2*j];
				load_val[j].col = seq_e[2*j+1];
			end else begin
				load_val[j].row = seq_d[j];
				load_val[j].col = '0;
				for (int i = 0; i < 2 * PERIOD; i++) begin
					if ((IW'(j) + IW'(len_q)) == IW'(i)) begin
						load_val[j].col = seq_d[i];
					end
				end
			end
		end
	end

	assign ctl.load  = xfer;
	assign ctl.shift = out_acc;

	for (genvar g = 0; g < PERIOD; g++) begin : g_chain
		bcp_pkg::coord_t next_val;
		if (g == PERIOD - 1) begin : g_tail
			assign next_val = '0;
		end else begin : g_mid
			assign next_val = chain[g+1];
		end
		bcp_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.load_val (load_val[g]),
			.next_val (next_val),
			.val      (chain[g])
		);
	end

	assign out_item.out_letter = bcp_pkg::sq_cell(sq_flat, chain[0]);
	assign out_item.end_of_run = (out_cnt_q == CNT_W'(1));

	ap_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= CNT_W'(PERIOD))
		else $error("output count above period");

	ap_last_pends: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.last |=> pending_q && (fill_q == '0))
		else $error("last item did not close the block");

	ap_full_pends: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (fill_q == FILL_W'(PERIOD - 1)) |=> pending_q)
		else $error("full block not pending");

	ap_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_item.end_of_run && !pending_q |=> !out_valid)
		else $error("results after end of run");

endmodule

>>> hw/rtl/bcp_locate.sv
// bcp_locate: finds the row and column of a letter in the keyed square
// depends on bcp_pkg

module bcp_locate (
	input  logic [bcp_pkg::SQ_W-1:0]     sq_flat,
	input  logic [bcp_pkg::LETTER_W-1:0] letter,
	output bcp_pkg::coord_t              loc
);

	logic [bcp_pkg::LETTER_W-1:0] key;

	always_comb begin
		key = (letter == bcp_pkg::LETTER_J) ? bcp_pkg::LETTER_I : letter;
		loc = '0;
		// walk downwards so the lowest matching cell wins, no match gives row 0 column 0
		for (int n = bcp_pkg::CELLS - 1; n >= 0; n--) begin
			if (sq_flat[n*bcp_pkg::LETTER_W +: bcp_pkg::LETTER_W] == key) begin
				loc.row = bcp_pkg::COORD_W'(n / bcp_pkg::SIDE);
				loc.col = bcp_pkg::COORD_W'(n % bcp_pkg::SIDE);
			end
		end
	end

endmodule

>>> hw/rtl/bcp_cell.sv
// bcp_cell: one stage of the output chain, holds a row and column selector pair
// depends on bcp_pkg

module bcp_cell (
	input  logic                   clk,
	input  bcp_pkg::chain_ctl_t    ctl,
	input  bcp_pkg::coord_t        load_val,
	input  bcp_pkg::coord_t        next_val,
	output bcp_pkg::coord_t        val
);

	bcp_pkg::coord_t val_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_q <= load_val;
		end else if (ctl.shift) begin
			val_q <= next_val;
		end
	end

	assign val = val_q;

endmodule
